// ----- design/well_pkg.sv -----
// Shared types and constants for the WELL512a word generator.
package well_pkg;

	localparam int unsigned RING_DEPTH = 16;
	localparam int unsigned HALF_WORDS = RING_DEPTH / 2;
	localparam int unsigned IDX_W      = $clog2(RING_DEPTH);

	typedef logic [31:0]      word_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [63:0]      seed_t;

	// operation codes
	localparam logic OP_DRAW   = 1'b0;
	localparam logic OP_RESEED = 1'b1;

	// seed chain and tempering constants
	localparam word_t CHAIN_MUL   = 32'h0017_6357;
	localparam word_t CHAIN_ADD   = 32'h0003_8562;
	localparam word_t TEMPER_MASK = 32'hDA44_2D24;

	// ring offsets used by a draw, and the last indices of the seed fill
	localparam idx_t OFS_M1 = idx_t'(13);
	localparam idx_t OFS_M2 = idx_t'(9);
	localparam idx_t LAST_LO = idx_t'(HALF_WORDS - 1);
	localparam idx_t LAST_IDX = idx_t'(RING_DEPTH - 1);

	// ring write port
	typedef struct packed {
		logic  en;
		idx_t  addr;
		word_t data;
	} ring_wr_t;

	// ring read addresses
	typedef struct packed {
		idx_t addr_a;
		idx_t addr_b;
	} ring_rd_t;

	typedef enum logic [2:0] {
		ST_SEED,
		ST_IDLE,
		ST_D1,
		ST_D2,
		ST_D3,
		ST_PUSH
	} state_t;

endpackage

// ----- design/well_ring_ram.sv -----
// Sixteen-word state ring: one write port, two registered read ports.
module well_ring_ram (
	input  logic                clk,
	input  well_pkg::ring_wr_t  wr,
	input  well_pkg::ring_rd_t  rd,
	output well_pkg::word_t     rd_data_a,
	output well_pkg::word_t     rd_data_b
);
	import well_pkg::*;

	word_t mem [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_a <= mem[rd.addr_a];
		rd_data_b <= mem[rd.addr_b];
	end

endmodule

// ----- design/well512_word_generator_unit.sv -----
// WELL512a word generator top level: sequencer, datapath and output register.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------------
//  input   | in_valid  | in_stall  | operation, seed_value
//  output  | out_valid | out_stall | random_word
//
// A draw holds the input through idle/accept, two read states (both
// read ports), one write state per new ring word, then the push. out_valid
// is registered from the push, after D1, D2 and D3. A reseed holds it through
// accept, then a sixteen-word fill, one chain word per cycle through the write port.
// After reset the same fill runs with seed zero; in_stall is low only while idle.
// A waiting word is kept in the output register; a draw holds before its push.
module well512_word_generator_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            operation,
	input  well_pkg::seed_t seed_value,
	output logic            out_valid,
	input  logic            out_stall,
	output well_pkg::word_t random_word
);
	import well_pkg::*;

	state_t   state_q, state_d;
	idx_t     index_q;
	idx_t     seed_cnt_q;
	word_t    chain_q;     // current seed chain word
	word_t    seed_hi_q;   // start of the upper half chain
	word_t    b_q;         // first mixing term
	word_t    word_q;      // drawn word before push
	logic     out_valid_q;
	word_t    out_word_q;

	ring_wr_t ring_wr;
	ring_rd_t ring_rd;
	word_t    rd_a, rd_b;

	logic     in_take, out_take, push;
	word_t    chain_next;
	word_t    c_mix, n_new, d_mix, word_new;
	idx_t     index_prev;

	well_ring_ram u_ring (
		.clk       (clk),
		.wr        (ring_wr),
		.rd        (ring_rd),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	assign in_take    = in_valid && !in_stall;
	assign out_take   = out_valid_q && !out_stall;
	assign index_prev = index_q - idx_t'(1);

	// shared chain unit: x * mul + add, low 32 bits
	assign chain_next = word_t'(chain_q * CHAIN_MUL) + CHAIN_ADD;

	// D2 mixing: rd_a = w[i+9], rd_b = w[i-1]
	assign c_mix    = rd_a ^ (rd_a >> 11);
	assign n_new    = b_q ^ c_mix;
	assign d_mix    = n_new ^ ((n_new << 5) & TEMPER_MASK);
	assign word_new = rd_b ^ b_q ^ d_mix ^ (rd_b << 2) ^ (b_q << 18) ^ (c_mix << 28);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_SEED: begin
				if (seed_cnt_q == LAST_IDX) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_take) state_d = (operation == OP_RESEED) ? ST_SEED : ST_D1;
			end
			ST_D1:   state_d = ST_D2;
			ST_D2:   state_d = ST_D3;
			ST_D3:   state_d = ST_PUSH;
			ST_PUSH: begin
				if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall       = 1'b1;
		push           = 1'b0;
		ring_wr.en     = 1'b0;
		ring_wr.addr   = index_q;
		ring_wr.data   = n_new;
		ring_rd.addr_a = index_q;
		ring_rd.addr_b = index_q + OFS_M1;
		unique case (state_q)
			ST_SEED: begin
				ring_wr.en   = 1'b1;
				ring_wr.addr = seed_cnt_q;
				ring_wr.data = chain_q;
			end
			ST_IDLE: in_stall = 1'b0;
			ST_D1: begin
				ring_rd.addr_a = index_q + OFS_M2;
				ring_rd.addr_b = index_prev;
			end
			ST_D2: ring_wr.en = 1'b1;
			ST_D3: begin
				ring_wr.en   = 1'b1;
				ring_wr.addr = index_prev;
				ring_wr.data = word_q;
			end
			ST_PUSH: push = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SEED;
			index_q     <= '0;
			seed_cnt_q  <= '0;
			chain_q     <= '0;
			seed_hi_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_take && operation == OP_RESEED) begin
				chain_q    <= seed_value[31:0];
				seed_hi_q  <= seed_value[63:32];
				seed_cnt_q <= '0;
			end
			if (state_q == ST_SEED) begin
				seed_cnt_q <= seed_cnt_q + idx_t'(1);
				chain_q    <= (seed_cnt_q == LAST_LO) ? seed_hi_q : chain_next;
				if (seed_cnt_q == LAST_IDX) index_q <= '0;
			end
			if (state_q == ST_D3) index_q <= index_prev;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_D1) b_q <= rd_a ^ rd_b ^ (rd_a << 16) ^ (rd_b << 15);
		if (state_q == ST_D2) word_q <= word_new;
		if (push) out_word_q <= word_q;
	end

	assign out_valid   = out_valid_q;
	assign random_word = out_word_q;

	// index steps down by one per draw
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_D3 |=> index_q == $past(index_prev))
		else $error("ring index did not step down after draw");

	// a result only appears after a draw's push
	a_push_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_PUSH)
		else $error("result raised outside push");

	// ring is never written while items are being accepted
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !ring_wr.en)
		else $error("ring written while idle");

endmodule
